// ===== sv/crc_perfect_hash_index_macros.svh =====
// Assertion macros for the lookup block's RTL, used by crc_perfect_hash_index.sv.
// Depends on signals named clk and rst in the scope where a macro is used.
`ifndef CRC_PERFECT_HASH_INDEX_MACROS_SVH
`define CRC_PERFECT_HASH_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define CHPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CHPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHPI_ASSERT(label, prop, msg)
`define CHPI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/chpi_pkg.sv =====
// Shared types, constants and CRC32C functions for the perfect-hash lookup.
// No dependencies.
package chpi_pkg;

  localparam int TABLE_ADDR_BITS_DEF = 12;
  localparam int KEY_W = 32;
  localparam int SLOT_W = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int ROT_AMOUNT = 15;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_ONE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_TWO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_THREE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_MASK = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_MASK = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  seed_one;
    logic [KEY_W-1:0]  seed_two;
    logic [KEY_W-1:0]  seed_three;
    logic [SLOT_W-1:0] slot_mask;
    logic [KEY_W-1:0]  result_mask;
  } cfg_t;

  typedef logic [31:0][31:0] crc_matrix_t;

  // Row i is the CRC step applied to a word with only bit i set.
  function automatic crc_matrix_t crc_build_matrix();
    crc_matrix_t m;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'd1 << i;
      for (int j = 0; j < 32; j++) begin
        c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      end
      m[i] = c;
    end
    return m;
  endfunction

  localparam crc_matrix_t CRC_MATRIX = crc_build_matrix();

  // The step is linear without inversion, so it is an XOR of matrix rows.
  function automatic logic [31:0] crc32c_step(logic [31:0] seed, logic [31:0] data);
    logic [31:0] x;
    logic [31:0] r;
    x = seed ^ data;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ CRC_MATRIX[i];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rotl_key(logic [31:0] v);
    return (v << ROT_AMOUNT) | (v >> (32 - ROT_AMOUNT));
  endfunction

endpackage

// ===== sv/crc_perfect_hash_index.sv =====
// A lookup beat passes through the s1 registers, the registered RAM reads and the hash_index output register.
// Throughput: one beat per cycle unless out_ready stalls the pipeline; the two table reads use two mirrored RAMs.
// Each write beat goes to both RAMs in the same stage that issues the reads.
// Reset clears the pipeline valids and the configuration registers.
// The vertex table is not cleared; entries must be written before use.
`include "crc_perfect_hash_index_macros.svh"
module crc_perfect_hash_index #(
  parameter int TABLE_ADDR_BITS = chpi_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [chpi_pkg::KEY_W-1:0]       lookup_key,
  input  logic [chpi_pkg::SLOT_W-1:0]      entry_addr,
  input  logic [chpi_pkg::KEY_W-1:0]       entry_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [chpi_pkg::KEY_W-1:0]       hash_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chpi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chpi_pkg::KEY_W-1:0]       cfg_data
);

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;

  chpi_pkg::cfg_t cfg;

  logic                       s1_valid;
  logic                       s1_write;
  logic [31:0]                s1_a;
  logic [31:0]                s1_b;
  logic [31:0]                s1_c;
  logic [TABLE_ADDR_BITS-1:0] s1_addr;
  logic [31:0]                s1_value;
  logic                       s2_valid;

  logic                       out_load;
  logic                       s2_move;
  logic                       s1_move;
  logic                       in_fire;
  logic [31:0]                d_hash;
  logic                       ram_we;
  logic                       ram_re;
  logic [TABLE_ADDR_BITS-1:0] raddr_a;
  logic [TABLE_ADDR_BITS-1:0] raddr_d;
  logic [31:0]                rdata_a;
  logic [31:0]                rdata_d;

  assign cfg_ready = 1'b1;

  chpi_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_load = !out_valid || out_ready;
  assign s2_move = !s2_valid || out_load;
  assign s1_move = !s1_valid || s2_move;
  assign in_ready = s1_move;
  assign in_fire = in_valid && s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_write <= req_type;
      s1_a <= chpi_pkg::crc32c_step(cfg.seed_one, lookup_key);
      s1_b <= chpi_pkg::crc32c_step(cfg.seed_two, chpi_pkg::rotl_key(lookup_key));
      s1_c <= lookup_key ^ cfg.seed_three;
      s1_addr <= TABLE_ADDR_BITS'(entry_addr);
      s1_value <= entry_value;
    end
  end

  assign d_hash = chpi_pkg::crc32c_step(s1_b, s1_c);
  assign raddr_a = TABLE_ADDR_BITS'(s1_a[chpi_pkg::SLOT_W-1:0] & cfg.slot_mask);
  assign raddr_d = TABLE_ADDR_BITS'(d_hash[chpi_pkg::SLOT_W-1:0] & cfg.slot_mask);
  assign ram_we = s1_valid && s1_write && s1_move;
  assign ram_re = s1_valid && !s1_write && s2_move;

  chpi_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_value),
    .re    (ram_re),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  chpi_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram_d (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_value),
    .re    (ram_re),
    .raddr (raddr_d),
    .rdata (rdata_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_move) begin
      s2_valid <= s1_valid && !s1_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid) begin
      hash_index <= (rdata_a + rdata_d) & cfg.result_mask;
    end
  end

  `CHPI_ASSERT(a_no_reread_on_stall, !(s2_valid && !out_load && ram_re), "stalled read reissued")
  `CHPI_ASSERT(a_write_read_exclusive, !(ram_we && ram_re), "table write and read together")
  `CHPI_ASSERT_NEXT(a_read_fills_s2, ram_re, s2_valid, "issued read lost")
  `CHPI_ASSERT_NEXT(a_no_phantom_result, !s2_valid && out_load, !out_valid, "phantom result beat")

endmodule

// ===== sv/chpi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module chpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/chpi_cfg.sv =====
// Configuration register file for the perfect-hash lookup.
// Depends on chpi_pkg.
module chpi_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [chpi_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [chpi_pkg::KEY_W-1:0]        wr_data,
  output chpi_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed_one <= '0;
      cfg.seed_two <= '0;
      cfg.seed_three <= '0;
      cfg.slot_mask <= '1;
      cfg.result_mask <= '1;
    end else if (wr_en) begin
      case (wr_index)
        chpi_pkg::CFG_SEED_ONE: begin
          cfg.seed_one <= wr_data;
        end
        chpi_pkg::CFG_SEED_TWO: begin
          cfg.seed_two <= wr_data;
        end
        chpi_pkg::CFG_SEED_THREE: begin
          cfg.seed_three <= wr_data;
        end
        chpi_pkg::CFG_SLOT_MASK: begin
          cfg.slot_mask <= wr_data[chpi_pkg::SLOT_W-1:0];
        end
        chpi_pkg::CFG_RESULT_MASK: begin
          cfg.result_mask <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for crc_perfect_hash_index: a directed table and then randomized phases, checked against
// known results or a CRC32C vertex-table predictor. Needs chpi_pkg and the RTL only.
module tb_top;

  localparam int SLOT_W = chpi_pkg::SLOT_W;
  localparam int KEY_W = chpi_pkg::KEY_W;
  localparam int CFG_INDEX_W = chpi_pkg::CFG_INDEX_W;
  localparam int TABLE_DEPTH = 1 << chpi_pkg::TABLE_ADDR_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 105;
  localparam int DIR_ROWS = 18;

  typedef enum logic {REQ_LOOKUP = 1'b0, REQ_WRITE = 1'b1} req_kind_t;

  typedef struct packed {
    logic        stage;
    req_kind_t   kind;
    logic [31:0] key;
    logic [SLOT_W-1:0] addr;
    logic [31:0] value;
    logic        known;
    logic [31:0] known_index;
  } dir_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [KEY_W-1:0] lookup_key;
  logic [SLOT_W-1:0] entry_addr;
  logic [KEY_W-1:0] entry_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] hash_index;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [KEY_W-1:0] cfg_data;

  chpi_pkg::cfg_t cfg_model;
  logic [31:0] vertex_model [TABLE_DEPTH];
  bit written [TABLE_DEPTH];
  logic [31:0] pending_index [$];
  logic [31:0] expected_index;
  dir_row_t dir_rows [DIR_ROWS];

  int errors = 0;
  int lookups_sent;
  int writes_sent;
  int results_seen = 0;
  int config_sets;
  int idle_cycles = 0;
  int send_idle_pct;
  int stall_pct;
  int hold_tag;
  int hold_seen = 0;
  int hold_cnt = 0;

  crc_perfect_hash_index u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .lookup_key(lookup_key),
    .entry_addr(entry_addr),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hash_index(hash_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [31:0] crc32c_word(logic [31:0] seed, logic [31:0] data);
    logic [31:0] c;
    c = seed ^ data;
    for (int i = 0; i < 32; i++) begin
      c = (c >> 1) ^ (c[0] ? chpi_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic void lookup_slots(input logic [31:0] key, output logic [SLOT_W-1:0] sa,
                                       output logic [SLOT_W-1:0] sd);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    a = crc32c_word(cfg_model.seed_one, key);
    b = crc32c_word(cfg_model.seed_two, {key[16:0], key[31:17]});
    d = crc32c_word(b, key ^ cfg_model.seed_three);
    sa = a[SLOT_W-1:0] & cfg_model.slot_mask;
    sd = d[SLOT_W-1:0] & cfg_model.slot_mask;
  endfunction

  function automatic logic [31:0] predict_index(logic [31:0] key);
    logic [SLOT_W-1:0] sa;
    logic [SLOT_W-1:0] sd;
    lookup_slots(key, sa, sd);
    return (vertex_model[sa] + vertex_model[sd]) & cfg_model.result_mask;
  endfunction

  task automatic send_beat(req_kind_t kind, logic [31:0] key, logic [SLOT_W-1:0] addr,
                           logic [31:0] value, logic known, logic [31:0] known_index);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    lookup_key <= key;
    entry_addr <= addr;
    entry_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_WRITE) begin
      vertex_model[addr] = value;
      written[addr] = 1'b1;
      writes_sent++;
    end else begin
      pending_index.push_back(known ? known_index : predict_index(key));
      lookups_sent++;
    end
  endtask

  // Slots the key will read are written first, so no lookup touches an unwritten entry.
  task automatic issue_lookup(logic [31:0] key, logic known, logic [31:0] known_index);
    logic [SLOT_W-1:0] sa;
    logic [SLOT_W-1:0] sd;
    lookup_slots(key, sa, sd);
    if (!written[sa]) send_beat(REQ_WRITE, $urandom, sa, $urandom, 1'b0, 32'd0);
    if (!written[sd]) send_beat(REQ_WRITE, $urandom, sd, $urandom, 1'b0, 32'd0);
    send_beat(REQ_LOOKUP, key, SLOT_W'($urandom), $urandom, known, known_index);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      chpi_pkg::CFG_SEED_ONE: cfg_model.seed_one = data;
      chpi_pkg::CFG_SEED_TWO: cfg_model.seed_two = data;
      chpi_pkg::CFG_SEED_THREE: cfg_model.seed_three = data;
      chpi_pkg::CFG_SLOT_MASK: cfg_model.slot_mask = data[SLOT_W-1:0];
      chpi_pkg::CFG_RESULT_MASK: cfg_model.result_mask = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper bits of the slot mask word and the unused indexes carry noise that must be dropped.
  task automatic apply_cfg(chpi_pkg::cfg_t c);
    logic [31:0] mask_word;
    mask_word = $urandom;
    mask_word[SLOT_W-1:0] = c.slot_mask;
    cfg_write(chpi_pkg::CFG_SEED_ONE, c.seed_one);
    cfg_write(chpi_pkg::CFG_SEED_TWO, c.seed_two);
    cfg_write(chpi_pkg::CFG_SEED_THREE, c.seed_three);
    cfg_write(chpi_pkg::CFG_SLOT_MASK, mask_word);
    cfg_write(chpi_pkg::CFG_RESULT_MASK, c.result_mask);
    for (int r = chpi_pkg::CFG_RESULT_MASK + 1; r < (1 << CFG_INDEX_W); r++) begin
      cfg_write(CFG_INDEX_W'(r), $urandom);
    end
    config_sets++;
  endtask

  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_index.size() == 0) begin
          errors++;
          $display("%0t: hash_index beat with none expected, expected none, got %h",
                   $time, hash_index);
        end else begin
          expected_index = pending_index.pop_front();
          if (hash_index !== expected_index) begin
            errors++;
            $display("%0t: hash_index mismatch, expected %h, got %h",
                     $time, expected_index, hash_index);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_index.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    chpi_pkg::cfg_t c;
    int roll;
    int phase_start;
    bit hold_done;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_LOOKUP;
    lookup_key = '0;
    entry_addr = '0;
    entry_value = '0;
    cfg_valid = 1'b0;
    cfg_index = chpi_pkg::CFG_SEED_ONE;
    cfg_data = '0;
    lookups_sent = 0;
    writes_sent = 0;
    config_sets = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_tag = 0;
    hold_done = 1'b0;
    cfg_model = '{32'h0, 32'h0, 32'h0, 12'hFFF, 32'hFFFF_FFFF};

    // Stage 0 runs with the slot mask cleared, so both reads hit slot zero and the
    // result is twice that word, wrapped and masked.
    dir_rows = '{
      '{1'b0, REQ_WRITE,  32'h0000_0000, 12'h000, 32'h8000_0001, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_WRITE,  32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0000, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0002},
      '{1'b0, REQ_LOOKUP, 32'hFFFF_FFFF, 12'h000, 32'h0000_0000, 1'b1, 32'h0000_0002},
      '{1'b0, REQ_LOOKUP, 32'h8000_0000, 12'hAAA, 32'h5555_5555, 1'b1, 32'h0000_0002},
      '{1'b0, REQ_LOOKUP, 32'h0000_0001, 12'h555, 32'hAAAA_AAAA, 1'b1, 32'h0000_0002},
      '{1'b0, REQ_WRITE,  32'h0000_0000, 12'h000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h7FFF_FFFF, 12'h000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFE},
      '{1'b0, REQ_WRITE,  32'hFFFF_FFFF, 12'h000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'hAAAA_AAAA, 12'h000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{1'b0, REQ_WRITE,  32'h0000_0000, 12'h000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h5555_5555, 12'h000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFE},
      '{1'b0, REQ_WRITE,  32'h0000_0000, 12'h800, 32'h1234_5678, 1'b0, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h1234_5678, 12'h000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFE},
      '{1'b1, REQ_LOOKUP, 32'h0000_0000, 12'h000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{1'b1, REQ_LOOKUP, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{1'b1, REQ_LOOKUP, 32'h8000_0000, 12'h000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{1'b1, REQ_LOOKUP, 32'h0000_0001, 12'h000, 32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_cfg('{32'h0, 32'h0, 32'h0, 12'h000, 32'hFFFF_FFFF});
    foreach (dir_rows[i]) begin
      if (i > 0 && dir_rows[i].stage != dir_rows[i-1].stage) begin
        drain();
        apply_cfg('{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF});
      end
      if (dir_rows[i].kind == REQ_WRITE) begin
        send_beat(REQ_WRITE, dir_rows[i].key, dir_rows[i].addr, dir_rows[i].value,
                  1'b0, 32'd0);
      end else begin
        issue_lookup(dir_rows[i].key, dir_rows[i].known, dir_rows[i].known_index);
      end
    end
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      case (p)
        0: c = '{32'h0, 32'h0, 32'h0, 12'h00F, 32'hFFFF_FFFF};
        1: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h03F, 32'h0};
        2: c = '{$urandom, $urandom, $urandom, 12'hFFF, $urandom};
        3: c = '{$urandom, $urandom, $urandom, 12'h000, 32'hFFFF_FFFF};
        4: c = '{$urandom, $urandom, $urandom, SLOT_W'($urandom_range(4095)), 32'h0000_FFFF};
        5: c = '{32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 12'h800, 32'h8000_0000};
        6: c = '{$urandom, $urandom, $urandom, 12'h0FF, $urandom};
        7: c = '{$urandom, $urandom, $urandom, 12'hFFF, 32'hFFFF_FFFF};
        default: c = '{$urandom, $urandom, $urandom, SLOT_W'($urandom), $urandom};
      endcase
      apply_cfg(c);
      phase_start = lookups_sent + writes_sent;
      while (lookups_sent + writes_sent - phase_start < PHASE_ITEMS) begin
        if (p == 0 && !hold_done && lookups_sent + writes_sent - phase_start >= 20) begin
          hold_tag++;
          hold_done = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 65) begin
          issue_lookup($urandom, 1'b0, 32'd0);
        end else if (roll < 85) begin
          send_beat(REQ_WRITE, $urandom, SLOT_W'($urandom_range(4095)) & cfg_model.slot_mask,
                    $urandom, 1'b0, 32'd0);
        end else begin
          send_beat(REQ_WRITE, $urandom, SLOT_W'($urandom_range(4095)), $urandom, 1'b0, 32'd0);
        end
      end
      drain();
    end

    $display("Ran %0d lookups and %0d table writes under %0d configurations.",
             lookups_sent, writes_sent, config_sets);
    $display("Checked %0d hash_index beats, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
